@@ design/pq_lut_distance_sum_assert.svh @@
// assertion macros for the design file pq_lut_distance_sum.sv
`ifndef PQ_LUT_DISTANCE_SUM_ASSERT_SVH
`define PQ_LUT_DISTANCE_SUM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent in the same cycle
`define PQLD_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the next cycle
`define PQLD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PQLD_ASSERT_NOW(name, clk, rst, ante, cons, msg)
`define PQLD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

@@ design/pqld_pkg.sv @@
package pqld_pkg;

   localparam int CODE_W      = 8;
   localparam int CODE_COUNT  = 16;
   localparam int MAX_TABLES  = 16;
   localparam int GROUP_SIZE  = 4;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  sub_index;
      logic [7:0]  entry_index;
      logic [31:0] entry_value;
      logic [31:0] vector_id;
      logic [63:0] codes_low;
      logic [63:0] codes_high;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] result_id;
      logic [31:0] distance;
      logic        saturated;
   } rsp_beat_type;

endpackage

@@ design/pq_lut_distance_sum.sv @@
// product-quantization distance sum over per-subspace lookup tables
//
// req channel: a beat with req_type write stores entry_value into entry
// entry_index of table sub_index and gives no response; a beat with
// req_type lookup reads one entry per subspace, chosen by the code bytes in
// codes_low/codes_high, and gives one rsp beat with vector_id, the sum and
// a saturation flag.
// throughput: one beat per cycle while req_stall is low, writes and lookups
// mixed freely; a write is visible to any lookup accepted after it.
// an accepted lookup passes the table read register, group adder stage,
// final adder stage and output register before it shows on rsp.
// each subspace table is its own one-write one-read memory, so all entries
// are read in the acceptance cycle.
// reset clears only the pipeline valid bits; table contents stay undefined
// until written.
// rsp_stall holds the output register; the stages behind it keep filling
// through their bubbles, and req_stall rises only once the first stage is
// full and cannot move.
`include "pq_lut_distance_sum_assert.svh"

module pq_lut_distance_sum
   import pqld_pkg::*;
#(
   parameter int NUM_SUBSPACES = 16,
   parameter int CODEBOOK_SIZE = 256,
   parameter int DIST_WIDTH    = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data
);

   localparam int NUM_TABLES = (NUM_SUBSPACES < MAX_TABLES) ? NUM_SUBSPACES : MAX_TABLES;
   localparam int NUM_GROUPS = (NUM_TABLES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int IDX_W      = $clog2(CODEBOOK_SIZE);
   localparam int GRP_W      = DIST_WIDTH + 2;
   localparam int SUM_W      = DIST_WIDTH + 4;

   // code to entry, code wraps modulo the codebook size
   logic [IDX_W-1:0] mod_lut [256];

   logic [CODE_W*CODE_COUNT-1:0] codes;
   logic                         req_accept;
   logic                         wr_en;

   logic en1, en2, en3, en4;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic [31:0]           id1_ff, id2_ff, id3_ff;
   logic [DIST_WIDTH-1:0] rd_data [NUM_GROUPS*GROUP_SIZE];
   logic [GRP_W-1:0]      grp_in  [NUM_GROUPS];
   logic [GRP_W-1:0]      grp_ff  [NUM_GROUPS];
   logic [SUM_W-1:0]      sum_in;
   logic [SUM_W-1:0]      sum_ff;
   logic                  sat_in;
   rsp_beat_type          rsp_in;
   rsp_beat_type          rsp_ff;

   for (genvar i = 0; i < 256; i++) begin : g_mod
      assign mod_lut[i] = IDX_W'(i % CODEBOOK_SIZE);
   end

   // stall chain, a stage moves when the next one is empty or moving
   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall  = !en1;
   assign req_accept = req_valid && en1;
   assign codes      = {req_data.codes_high, req_data.codes_low};

   assign wr_en = req_accept && (req_data.req_type == REQ_WRITE)
                  && (32'(req_data.sub_index) < NUM_TABLES)
                  && (32'(req_data.entry_index) < CODEBOOK_SIZE);

   // one table memory per subspace, read data registered in stage 1
   for (genvar s = 0; s < NUM_TABLES; s++) begin : g_tbl
      logic [DIST_WIDTH-1:0] tbl_mem [CODEBOOK_SIZE];
      logic [DIST_WIDTH-1:0] rd_ff;
      logic                  we;

      assign we = wr_en && (req_data.sub_index == 4'(s));

      always_ff @(posedge clock) begin
         if (we) begin
            tbl_mem[req_data.entry_index[IDX_W-1:0]] <= req_data.entry_value[DIST_WIDTH-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en1) begin
            rd_ff <= tbl_mem[mod_lut[codes[CODE_W*s +: CODE_W]]];
         end
      end

      assign rd_data[s] = rd_ff;
   end

   for (genvar p = NUM_TABLES; p < NUM_GROUPS*GROUP_SIZE; p++) begin : g_pad
      assign rd_data[p] = '0;
   end

   // stage 2: groups of four
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            grp_in[g] = grp_in[g] + GRP_W'(rd_data[g*GROUP_SIZE + k]);
         end
      end
   end

   // stage 3: group sums
   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sum_in = sum_in + SUM_W'(grp_ff[g]);
      end
   end

   // stage 4: saturate into the output register
   always_comb begin
      sat_in           = |sum_ff[SUM_W-1:DIST_WIDTH];
      rsp_in.result_id = id3_ff;
      rsp_in.saturated = sat_in;
      rsp_in.distance  = sat_in ? 32'({DIST_WIDTH{1'b1}}) : 32'(sum_ff[DIST_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid && (req_data.req_type == REQ_LOOKUP);
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) id1_ff <= req_data.vector_id;
      if (en2) begin
         id2_ff <= id1_ff;
         grp_ff <= grp_in;
      end
      if (en3) begin
         id3_ff <= id2_ff;
         sum_ff <= sum_in;
      end
      if (en4) rsp_ff <= rsp_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

   `PQLD_ASSERT_NEXT(a_lookup_enters, clock, reset, req_valid && !req_stall && req_data.req_type == REQ_LOOKUP, v1_ff, "accepted lookup did not enter the pipeline")
   `PQLD_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall, v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall, "input stalled with a free stage")
   `PQLD_ASSERT_NEXT(a_stage3_holds, clock, reset, v3_ff && !en3, v3_ff && $stable(sum_ff) && $stable(id3_ff), "stalled stage 3 lost its beat")
   `PQLD_ASSERT_NOW(a_sat_max, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.distance == 32'({DIST_WIDTH{1'b1}}), "saturated beat without full-scale distance")

endmodule
